@@ design/stt_pkg.sv @@
// Shared types, constants and lexer functions for the script text tokenizer.
`default_nettype none

package stt_pkg;

  // Sizes
  localparam int unsigned TokBufBytes = 4096;
  localparam int unsigned LenW        = 12;
  localparam logic [LenW-1:0] LenLimitMax = LenW'(TokBufBytes - 1);
  localparam int unsigned MaxResults  = 5;
  localparam int unsigned CntW        = 3;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QPtrW       = 2;
  localparam int unsigned QCntW       = 3;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 16;

  // Character codes
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_LEN    = 1'b0,
    CFG_HIGH_SPACE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    M_SKIP  = 3'd0,
    M_SLASH = 3'd1,
    M_LINE  = 3'd2,
    M_BLOCK = 3'd3,
    M_STAR  = 3'd4,
    M_WORD  = 3'd5,
    M_QUOTE = 3'd6,
    M_ESC   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLS_WORD   = 2'd0,
    CLS_QUOTED = 2'd1,
    CLS_PUNCT  = 2'd2
  } cls_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    cls_e       cls;
    logic       ovf;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0]              n;
    item_t [MaxResults-1:0]       items;
  } batch_t;

  typedef struct packed {
    mode_e           mode;
    logic [LenW-1:0] len;
    logic            ovf;
  } lex_t;

  typedef struct packed {
    lex_t   st;
    batch_t b;
  } work_t;

  typedef struct packed {
    logic [LenW-1:0] lim;
    logic            hspace;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic f_is_space(logic [7:0] c, logic hs);
    return (c <= ChSpace) || (c[7] && hs);
  endfunction

  function automatic logic f_is_punct(logic [7:0] c);
    return (c == ChLbrace) || (c == ChRbrace) || (c == ChLpar) ||
           (c == ChRpar) || (c == ChComma);
  endfunction

  // Add one result to the batch if it has room
  function automatic work_t f_emit(work_t w, kind_e k, logic [7:0] ch, cls_e cls,
                                   logic ovf);
    work_t r;
    r = w;
    if (r.b.n < CntW'(MaxResults)) begin
      r.b.items[r.b.n].kind = k;
      r.b.items[r.b.n].ch   = ch;
      r.b.items[r.b.n].cls  = cls;
      r.b.items[r.b.n].ovf  = ovf;
      r.b.n = r.b.n + CntW'(1);
    end
    return r;
  endfunction

  // Emit a token byte below the limit, else mark overflow
  function automatic work_t f_append(work_t w, logic [7:0] ch, cls_e cls, cfg_t cfg);
    work_t r;
    r = w;
    if (r.st.len < cfg.lim) begin
      r = f_emit(r, KIND_BYTE, ch, cls, 1'b0);
      r.st.len = r.st.len + LenW'(1);
    end else begin
      r.st.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t f_close(work_t w, cls_e cls);
    work_t r;
    r = f_emit(w, KIND_END, ChNul, cls, w.st.ovf);
    r.st.len  = '0;
    r.st.ovf  = 1'b0;
    r.st.mode = M_SKIP;
    return r;
  endfunction

  function automatic work_t f_start(work_t w, logic [7:0] c, cfg_t cfg);
    work_t r;
    r = w;
    if (f_is_space(c, cfg.hspace)) begin
      r = w;
    end else if (c == ChSlash) begin
      r.st.mode = M_SLASH;
    end else if (c == ChQuote) begin
      r.st.mode = M_QUOTE;
    end else if (f_is_punct(c)) begin
      r = f_append(r, c, CLS_PUNCT, cfg);
      r = f_close(r, CLS_PUNCT);
    end else begin
      r.st.mode = M_WORD;
      r = f_append(r, c, CLS_WORD, cfg);
    end
    return r;
  endfunction

  function automatic work_t f_word(work_t w, logic [7:0] c, cfg_t cfg);
    work_t r;
    r = w;
    if (f_is_space(c, cfg.hspace)) begin
      r = f_close(r, CLS_WORD);
    end else if (f_is_punct(c)) begin
      r = f_close(r, CLS_WORD);
      r = f_start(r, c, cfg);
    end else begin
      r = f_append(r, c, CLS_WORD, cfg);
    end
    return r;
  endfunction

  function automatic work_t f_quote(work_t w, logic [7:0] c, cfg_t cfg);
    work_t r;
    r = w;
    if (c == ChQuote) begin
      r = f_close(r, CLS_QUOTED);
    end else if (c == ChBslash) begin
      r.st.mode = M_ESC;
    end else if (c != ChCr) begin
      r = f_append(r, c, CLS_QUOTED, cfg);
    end
    return r;
  endfunction

  // One text byte in the current mode
  function automatic work_t f_handle(work_t w, logic [7:0] c, cfg_t cfg);
    work_t r;
    r = w;
    unique case (w.st.mode)
      M_SKIP:  r = f_start(r, c, cfg);
      M_SLASH: begin
        if (c == ChStar) begin
          r.st.mode = M_BLOCK;
        end else if (c == ChSlash) begin
          r.st.mode = M_LINE;
        end else begin
          r.st.mode = M_WORD;
          r = f_append(r, ChSlash, CLS_WORD, cfg);
          r = f_word(r, c, cfg);
        end
      end
      M_LINE: begin
        if (c == ChLf) r.st.mode = M_SKIP;
      end
      M_BLOCK: begin
        if (c == ChStar) r.st.mode = M_STAR;
      end
      M_STAR: begin
        if (c == ChSlash) r.st.mode = M_SKIP;
        else if (c != ChStar) r.st.mode = M_BLOCK;
      end
      M_WORD:  r = f_word(r, c, cfg);
      M_QUOTE: r = f_quote(r, c, cfg);
      M_ESC: begin
        r.st.mode = M_QUOTE;
        if (c == ChLowN) begin
          r = f_append(r, ChLf, CLS_QUOTED, cfg);
        end else if (c == ChLowT) begin
          r = f_append(r, ChTab, CLS_QUOTED, cfg);
        end else if (c == ChQuote) begin
          r = f_append(r, ChQuote, CLS_QUOTED, cfg);
        end else begin
          r = f_append(r, ChBslash, CLS_QUOTED, cfg);
          r = f_quote(r, c, cfg);
        end
      end
      default: r = w;
    endcase
    return r;
  endfunction

  // Close any open token, then end the text
  function automatic work_t f_finish(work_t w, cfg_t cfg);
    work_t r;
    r = w;
    unique case (w.st.mode)
      M_SLASH: begin
        r = f_append(r, ChSlash, CLS_WORD, cfg);
        r = f_close(r, CLS_WORD);
      end
      M_WORD:  r = f_close(r, CLS_WORD);
      M_QUOTE: r = f_close(r, CLS_QUOTED);
      M_ESC: begin
        r = f_append(r, ChBslash, CLS_QUOTED, cfg);
        r = f_close(r, CLS_QUOTED);
      end
      default: r = w;
    endcase
    r = f_emit(r, KIND_EOT, ChNul, CLS_WORD, 1'b0);
    r.st.mode = M_SKIP;
    r.st.len  = '0;
    r.st.ovf  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/script_text_tokenizer.sv @@
// Top level of the script text tokenizer: lexer, batch queue and output serializer.
//
//  Channel   Dir  Handshake                     Content
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: text_byte; tlast: end_of_text
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: char, class, overflow; tuser: kind
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i (write only)
//
// One text byte is taken each cycle while the four-entry batch queue has room.
// A byte yields zero to five results, sent one per cycle from the queue head while the
// output is ready, so the output port sets the sustained rate.
// The results of an accepted byte are registered in the batch queue before they are sent.
// Reset clears lexer state, queue pointers and registers to their reset values.
// A stalled output only fills the queue; input stalls once it is full.
`default_nettype none

module script_text_tokenizer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [stt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [stt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [stt_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] text_byte
  input  wire                          s_axis_tlast,  // end_of_text
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [stt_pkg::OutDataW-1:0] m_axis_tdata,  // [7:0] token_char, [9:8] token_class,
                                                      // [10] overflow, [15:11] zero
  output logic [1:0]                   m_axis_tuser,  // [1:0] item_kind
  output logic                         m_axis_tlast   // last_of_run
);
  import stt_pkg::*;

  q_stat_t q_stat;
  batch_t  push_batch, head;
  logic    push, pop;
  item_t   out_item;

  stt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_byte_i   (s_axis_tdata),
    .s_end_i    (s_axis_tlast),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .batch_o    (push_batch)
  );

  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .batch_i (push_batch),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  stt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_stat_i  (q_stat),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_item_o  (out_item),
    .m_last_o  (m_axis_tlast)
  );

  // Pack the output item
  assign m_axis_tdata = {5'b0, out_item.ovf, out_item.cls, out_item.ch};
  assign m_axis_tuser = out_item.kind;

  // Never write into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("push into full batch queue");

  // End of text is always the final result of its byte
  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_EOT) |-> m_axis_tlast)
    else $error("end of text not last of run");

  // Token bytes never carry the overflow flag
  a_byte_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_BYTE) |-> !m_axis_tdata[10])
    else $error("overflow flag on token byte");

  // Hold a stalled output transaction unchanged until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("output changed while stalled");

endmodule

`default_nettype wire

@@ design/stt_front.sv @@
// Front end: configuration registers and the lexer that turns one byte into a result batch.
`default_nettype none

module stt_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [stt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [stt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          s_valid_i,
  output logic                         s_ready_o,
  input  wire  [7:0]                   s_byte_i,
  input  wire                          s_end_i,
  input  stt_pkg::q_stat_t             q_stat_i,
  output logic                         push_o,
  output stt_pkg::batch_t              batch_o
);
  import stt_pkg::*;

  logic [LenW-1:0] max_len_q;
  logic            hspace_q;
  lex_t            lex_q, lex_d;
  cfg_t            cfg;
  work_t           w;
  logic            accept;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LenW'(4095);
      hspace_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_LEN:    max_len_q <= cfg_data_i[LenW-1:0];
        CFG_HIGH_SPACE: hspace_q  <= cfg_data_i[0];
        default:        max_len_q <= max_len_q;
      endcase
    end
  end

  // Clamp the limit to the token buffer
  always_comb begin
    cfg.lim    = (max_len_q > LenLimitMax) ? LenLimitMax : max_len_q;
    cfg.hspace = hspace_q;
  end

  // Lex one byte, closing the text on NUL or the end flag
  always_comb begin
    w.st = lex_q;
    w.b  = '0;
    if (s_byte_i == ChNul) begin
      w = f_finish(w, cfg);
    end else begin
      w = f_handle(w, s_byte_i, cfg);
      if (s_end_i) w = f_finish(w, cfg);
    end
  end

  assign s_ready_o = !q_stat_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = accept && (w.b.n != '0);
  assign batch_o   = w.b;
  assign lex_d     = accept ? w.st : lex_q;

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_q.mode <= M_SKIP;
      lex_q.len  <= '0;
      lex_q.ovf  <= 1'b0;
    end else begin
      lex_q <= lex_d;
    end
  end

endmodule

`default_nettype wire

@@ design/stt_queue.sv @@
// Short batch queue between the lexer and the output serializer.
`default_nettype none

module stt_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  stt_pkg::batch_t  batch_i,
  input  wire              pop_i,
  output stt_pkg::batch_t  head_o,
  output stt_pkg::q_stat_t stat_o
);
  import stt_pkg::*;

  batch_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store pushed batches
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= batch_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

`default_nettype wire

@@ design/stt_back.sv @@
// Back end: sends the results of the head batch one transaction at a time.
`default_nettype none

module stt_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  stt_pkg::batch_t  head_i,
  input  stt_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  wire              m_ready_i,
  output stt_pkg::item_t   m_item_o,
  output logic             m_last_o
);
  import stt_pkg::*;

  logic [CntW-1:0] idx_q;
  logic            fire;

  assign m_valid_o = !q_stat_i.empty;
  assign m_item_o  = head_i.items[idx_q];
  assign m_last_o  = (idx_q == (head_i.n - CntW'(1)));
  assign fire      = m_valid_o && m_ready_i;
  assign pop_o     = fire && m_last_o;

  // Step through the batch, wrap on its last result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= m_last_o ? '0 : idx_q + CntW'(1);
    end
  end

endmodule

`default_nettype wire
